/* rtl/core/asc_pkg.sv */
// ----------------------------------------------------------------------------
// asc_pkg
// Shared widths, register indexes and the command word between the step
// counter's controller and datapath.
// ----------------------------------------------------------------------------
package asc_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int OFFSET_BITS = 10;
  localparam int THRESH_BITS = 11;
  localparam int MAG_BITS    = 11;
  localparam int COUNT_BITS  = 16;

  // Deviation covers both the sample and the offset range.
  localparam int DEV_BITS  = (SAMPLE_BITS > OFFSET_BITS) ? SAMPLE_BITS : OFFSET_BITS;
  localparam int SQ_BITS   = 2 * DEV_BITS;
  localparam int SUM_BITS  = SQ_BITS + 2;
  localparam int ROOT_BITS = SUM_BITS / 2;
  localparam int REM_BITS  = ROOT_BITS + 3;
  localparam int MAGF_BITS = ROOT_BITS + 1;
  localparam int CNT_BITS  = $clog2(ROOT_BITS);

  localparam int MAG_MAX = (1 << MAG_BITS) - 1;

  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 5;
  localparam int REG_IDX_BITS  = 3;

  localparam logic [OFFSET_BITS-1:0] X_OFFSET_RST = OFFSET_BITS'(443);
  localparam logic [OFFSET_BITS-1:0] Y_OFFSET_RST = OFFSET_BITS'(493);
  localparam logic [OFFSET_BITS-1:0] Z_OFFSET_RST = OFFSET_BITS'(833);
  localparam logic [THRESH_BITS-1:0] RISE_RST     = THRESH_BITS'(75);
  localparam logic [THRESH_BITS-1:0] FALL_RST     = THRESH_BITS'(65);

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_X_OFFSET = 3'd0,
    REG_Y_OFFSET = 3'd1,
    REG_Z_OFFSET = 3'd2,
    REG_RISE     = 3'd3,
    REG_FALL     = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } axis_t;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] x_offset;
    logic [OFFSET_BITS-1:0] y_offset;
    logic [OFFSET_BITS-1:0] z_offset;
    logic [THRESH_BITS-1:0] rise_threshold;
    logic [THRESH_BITS-1:0] fall_threshold;
  } cfg_t;

  typedef struct packed {
    logic  capture;    // latch the accepted word, clear the accumulator
    logic  sq_en;      // square the deviation of one axis
    axis_t axis;
    logic  acc_en;     // add the last square into the accumulator
    logic  root_load;  // start the root with the finished sum
    logic  root_step;  // one digit of the square root
    logic  finish;     // round, update step state, load the result
  } cmd_t;

endpackage

/* rtl/core/asc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// asc_cfg_regs
// APB register file holding the axis offsets and the step thresholds.
// ----------------------------------------------------------------------------
module asc_cfg_regs import asc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output cfg_t                     cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[APB_ADDR_BITS-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_X_OFFSET: cfg_nxt.x_offset       = pwdata[OFFSET_BITS-1:0];
        REG_Y_OFFSET: cfg_nxt.y_offset       = pwdata[OFFSET_BITS-1:0];
        REG_Z_OFFSET: cfg_nxt.z_offset       = pwdata[OFFSET_BITS-1:0];
        REG_RISE:     cfg_nxt.rise_threshold = pwdata[THRESH_BITS-1:0];
        REG_FALL:     cfg_nxt.fall_threshold = pwdata[THRESH_BITS-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_offset       <= X_OFFSET_RST;
      cfg_r.y_offset       <= Y_OFFSET_RST;
      cfg_r.z_offset       <= Z_OFFSET_RST;
      cfg_r.rise_threshold <= RISE_RST;
      cfg_r.fall_threshold <= FALL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      REG_X_OFFSET: prdata = APB_DATA_BITS'(cfg_r.x_offset);
      REG_Y_OFFSET: prdata = APB_DATA_BITS'(cfg_r.y_offset);
      REG_Z_OFFSET: prdata = APB_DATA_BITS'(cfg_r.z_offset);
      REG_RISE:     prdata = APB_DATA_BITS'(cfg_r.rise_threshold);
      REG_FALL:     prdata = APB_DATA_BITS'(cfg_r.fall_threshold);
      default:      prdata = '0;
    endcase
  end

endmodule

/* rtl/core/asc_ctrl.sv */
// ----------------------------------------------------------------------------
// asc_ctrl
// Sequencer: squares the three axes over a shared multiplier, steps the
// square root one digit a cycle and hands the result to the output register.
// ----------------------------------------------------------------------------
module asc_ctrl import asc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SQ   = 4'b0010,
    ST_ROOT = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t              state_r;
  state_t              state_nxt;
  logic [CNT_BITS-1:0] cnt_r;
  logic [CNT_BITS-1:0] cnt_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic                slot_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.axis      = AX_X;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          cnt_nxt     = '0;
          state_nxt   = ST_SQ;
        end
      end
      ST_SQ: begin
        // Squares go out one per cycle; the accumulator adds each one from the square register.
        case (cnt_r[1:0])
          2'd0: begin
            cmd.sq_en = 1'b1;
            cmd.axis  = AX_X;
          end
          2'd1: begin
            cmd.sq_en  = 1'b1;
            cmd.axis   = AX_Y;
            cmd.acc_en = 1'b1;
          end
          2'd2: begin
            cmd.sq_en  = 1'b1;
            cmd.axis   = AX_Z;
            cmd.acc_en = 1'b1;
          end
          default: begin
            cmd.root_load = 1'b1;
          end
        endcase
        if (cnt_r[1:0] == 2'd3) begin
          cnt_nxt   = '0;
          state_nxt = ST_ROOT;
        end else begin
          cnt_nxt = cnt_r + CNT_BITS'(1);
        end
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (cnt_r == CNT_BITS'(ROOT_BITS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt = cnt_r + CNT_BITS'(1);
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/core/asc_datapath.sv */
// ----------------------------------------------------------------------------
// asc_datapath
// Offset removal, shared squarer, accumulator, digit-by-digit square root,
// rounding and the step hysteresis with its running count.
// ----------------------------------------------------------------------------
module asc_datapath import asc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cmd_t                   cmd,
  input  cfg_t                   cfg,
  input  logic [SAMPLE_BITS-1:0] x_sample,
  input  logic [SAMPLE_BITS-1:0] y_sample,
  input  logic [SAMPLE_BITS-1:0] z_sample,
  output logic [MAG_BITS-1:0]    magnitude,
  output logic                   step_pulse,
  output logic                   in_step_now,
  output logic [COUNT_BITS-1:0]  step_count
);

  logic [SAMPLE_BITS-1:0] x_r, y_r, z_r;
  logic [SQ_BITS-1:0]     sq_r;
  logic [SUM_BITS-1:0]    acc_r;
  logic [SUM_BITS-1:0]    sum_sh_r;
  logic [REM_BITS-1:0]    rem_r;
  logic [ROOT_BITS-1:0]   root_r;
  logic                   in_step_r;
  logic [COUNT_BITS-1:0]  total_r;
  logic [MAG_BITS-1:0]    mag_out_r;
  logic                   pulse_out_r;
  logic                   in_step_out_r;
  logic [COUNT_BITS-1:0]  count_out_r;

  logic [DEV_BITS-1:0]    smp;
  logic [DEV_BITS-1:0]    off;
  logic [DEV_BITS-1:0]    dev;
  logic [REM_BITS-1:0]    rem_sh;
  logic [REM_BITS-1:0]    trial;
  logic                   take;
  logic [MAGF_BITS-1:0]   mag_full;
  logic [MAG_BITS-1:0]    mag;
  logic                   pulse;
  logic                   in_step_rise;
  logic                   in_step_nxt;

  always_comb begin
    case (cmd.axis)
      AX_X:    begin smp = DEV_BITS'(x_r); off = DEV_BITS'(cfg.x_offset); end
      AX_Y:    begin smp = DEV_BITS'(y_r); off = DEV_BITS'(cfg.y_offset); end
      AX_Z:    begin smp = DEV_BITS'(z_r); off = DEV_BITS'(cfg.z_offset); end
      default: begin smp = '0;             off = '0;                      end
    endcase
    dev = (smp >= off) ? (smp - off) : (off - smp);
  end

  // One root digit: bring down the next bit pair and try (4*root + 1).
  assign rem_sh = {rem_r[REM_BITS-3:0], sum_sh_r[SUM_BITS-1 -: 2]};
  assign trial  = REM_BITS'({root_r, 2'b01});
  assign take   = (rem_sh >= trial);

  // The floor root rounds up when the remainder exceeds it.
  always_comb begin
    mag_full = MAGF_BITS'(root_r) + MAGF_BITS'(rem_r > REM_BITS'(root_r));
    if (mag_full > MAGF_BITS'(MAG_MAX)) begin
      mag = MAG_BITS'(MAG_MAX);
    end else begin
      mag = mag_full[MAG_BITS-1:0];
    end
    pulse        = (mag > cfg.rise_threshold) && !in_step_r;
    in_step_rise = in_step_r || pulse;
    in_step_nxt  = in_step_rise && !(mag < cfg.fall_threshold);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_r   <= x_sample;
      y_r   <= y_sample;
      z_r   <= z_sample;
      acc_r <= '0;
    end
    if (cmd.sq_en) begin
      sq_r <= SQ_BITS'(dev) * SQ_BITS'(dev);
    end
    if (cmd.acc_en) begin
      acc_r <= acc_r + SUM_BITS'(sq_r);
    end
    if (cmd.root_load) begin
      sum_sh_r <= acc_r + SUM_BITS'(sq_r);
      rem_r    <= '0;
      root_r   <= '0;
    end else if (cmd.root_step) begin
      sum_sh_r <= {sum_sh_r[SUM_BITS-3:0], 2'b00};
      rem_r    <= take ? (rem_sh - trial) : rem_sh;
      root_r   <= {root_r[ROOT_BITS-2:0], take};
    end
    if (cmd.finish) begin
      mag_out_r     <= mag;
      pulse_out_r   <= pulse;
      in_step_out_r <= in_step_nxt;
      count_out_r   <= total_r + COUNT_BITS'(pulse);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_step_r <= 1'b0;
      total_r   <= '0;
    end else if (cmd.finish) begin
      in_step_r <= in_step_nxt;
      total_r   <= total_r + COUNT_BITS'(pulse);
    end
  end

  assign magnitude   = mag_out_r;
  assign step_pulse  = pulse_out_r;
  assign in_step_now = in_step_out_r;
  assign step_count  = count_out_r;

endmodule

/* rtl/core/accel_step_counter.sv */
// ----------------------------------------------------------------------------
// accel_step_counter
// Each accepted word carries one three-axis accelerometer reading and yields
// one result: the rounded magnitude of the offset-corrected vector, a step
// pulse, the in-step mark and the running step count. A word is accepted
// only when the block is idle, after the last word's result is loaded into
// the output register. The single squarer works through the three axes and
// the accumulator, then the square root resolves one digit per cycle; the
// result is loaded once the output register is free. A finished result waits
// in the output register while the next word is already being worked on.
// Offsets and thresholds are to be written over the APB port only while no
// word is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module accel_step_counter import asc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [SAMPLE_BITS-1:0]   in_x_sample,
  input  logic [SAMPLE_BITS-1:0]   in_y_sample,
  input  logic [SAMPLE_BITS-1:0]   in_z_sample,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [MAG_BITS-1:0]      out_magnitude,
  output logic                     out_step_pulse,
  output logic                     out_in_step_now,
  output logic [COUNT_BITS-1:0]    out_step_count,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  cfg_t cfg;
  cmd_t cmd;

  asc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  asc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  asc_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cfg         (cfg),
    .x_sample    (in_x_sample),
    .y_sample    (in_y_sample),
    .z_sample    (in_z_sample),
    .magnitude   (out_magnitude),
    .step_pulse  (out_step_pulse),
    .in_step_now (out_in_step_now),
    .step_count  (out_step_count)
  );

endmodule

/* rtl/core/asc_checker.sv */
// ----------------------------------------------------------------------------
// asc_checker
// Port-level checks on the step counter: result hold, one word in flight,
// and consistency of the step count and pulse across delivered results.
// ----------------------------------------------------------------------------
module asc_checker import asc_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [MAG_BITS-1:0]      out_magnitude,
  input logic                     out_step_pulse,
  input logic                     out_in_step_now,
  input logic [COUNT_BITS-1:0]    out_step_count
);

  logic [COUNT_BITS-1:0] last_count_r;
  logic                  last_in_step_r;

  // Count and mark of the most recently delivered word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_count_r   <= '0;
      last_in_step_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      last_count_r   <= out_step_count;
      last_in_step_r <= out_in_step_now;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_magnitude) &&
      $stable(out_step_pulse) && $stable(out_in_step_now) && $stable(out_step_count)))
    else $error("result changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word accepted while one is in flight");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |->
      (out_step_count == COUNT_BITS'(last_count_r + COUNT_BITS'(out_step_pulse))))
    else $error("step count does not follow the pulse");

  a_pulse_outside_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_step_pulse) |-> !last_in_step_r)
    else $error("step counted while already inside a step");

endmodule

bind accel_step_counter asc_checker u_asc_checker (.*);
